// ===== hw/rtl/lcdt_pkg.sv =====
`timescale 1ns / 1ps

package lcdt_pkg;

    localparam int VIDEO_BYTES        = 8192;
    localparam int SPRITE_TABLE_BYTES = 160;
    localparam int VID_AW             = $clog2(VIDEO_BYTES);
    localparam int SPR_AW             = $clog2(SPRITE_TABLE_BYTES);

    localparam int NUM_REGS = 11;
    localparam int REG_AW   = $clog2(NUM_REGS);

    // commands
    localparam logic [2:0] CMD_TICK      = 3'd0;
    localparam logic [2:0] CMD_MEM_READ  = 3'd1;
    localparam logic [2:0] CMD_MEM_WRITE = 3'd2;
    localparam logic [2:0] CMD_REG_READ  = 3'd3;
    localparam logic [2:0] CMD_REG_WRITE = 3'd4;

    // register indexes
    localparam logic [3:0] REG_LCDC = 4'd0;
    localparam logic [3:0] REG_STAT = 4'd1;
    localparam logic [3:0] REG_LY   = 4'd4;
    localparam logic [3:0] REG_LYC  = 4'd5;

    // display modes
    localparam logic [1:0] MODE_HBL  = 2'd0;
    localparam logic [1:0] MODE_VBL  = 2'd1;
    localparam logic [1:0] MODE_OAM  = 2'd2;
    localparam logic [1:0] MODE_DRAW = 2'd3;

    localparam logic [8:0] LINE_DOTS   = 9'd457;
    localparam logic [8:0] DOT_DRAW    = 9'd80;
    localparam logic [8:0] DOT_HBLANK  = 9'd252;
    localparam logic [7:0] LINE_VBLANK = 8'd144;
    localparam logic [7:0] LINE_LAST   = 8'd153;
    localparam logic [7:0] STAT_WMASK  = 8'hFC;

    localparam logic [15:0] VRAM_BASE = 16'h8000;
    localparam logic [15:0] VRAM_END  = 16'hA000;
    localparam logic [15:0] OAM_BASE  = 16'hFE00;

    typedef enum logic [1:0] {
        RD_SRC_FIX,
        RD_SRC_VRAM,
        RD_SRC_OAM
    } t_rd_src;

    typedef struct packed {
        logic [2:0]  command;
        logic [15:0] address;
        logic [3:0]  register_index;
        logic [7:0]  write_data;
    } t_in_item;

    typedef struct packed {
        logic [7:0] read_data;
        logic [1:0] disp_mode;
        logic [7:0] current_line;
        logic [1:0] stat_requests;
        logic       vblank_request;
        logic       oam_scan_start;
        logic       line_render_start;
        logic       frame_done;
        logic       screen_clear;
    } t_out_item;

endpackage

// ===== hw/rtl/lcd_mode_line_timing_controller_top.sv =====
`timescale 1ns / 1ps

// lcd mode and line timing controller
// input channel (i_valid/o_ready, i_item): one transaction per dot tick,
// memory access or register access. output channel (o_valid/i_ready,
// o_item): exactly one result transaction per input transaction, in order.
// a result passes through the read stage and then the output register
// before it shows up on o_item; the read stage holds the registered read
// of video memory or the sprite table.
// throughput: one transaction per cycle unless stalled; at the accepting
// edge the register file and dot counter update and memories are read and
// written, so back-to-back accesses to one entry see each other in order.
// reset (synchronous, active low) clears the register file, dot counter
// and both valid flags; memory contents stay undefined until written.
// when the receiver stalls, the output register holds its result and one
// more transaction is taken into the read stage, then o_ready drops until
// the output register empties.

module lcd_mode_line_timing_controller_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  lcdt_pkg::t_in_item  i_item,
    output logic                o_valid,
    input  logic                i_ready,
    output lcdt_pkg::t_out_item o_item
);

    logic [7:0] r_vram [lcdt_pkg::VIDEO_BYTES];
    logic [7:0] r_oam  [lcdt_pkg::SPRITE_TABLE_BYTES];
    logic [7:0] r_vram_rdata;
    logic [7:0] r_oam_rdata;

    logic [7:0] r_regs [lcdt_pkg::NUM_REGS];
    logic [7:0] n_regs [lcdt_pkg::NUM_REGS];
    logic [8:0] r_dot;
    logic [8:0] n_dot;

    logic                r_s1_valid;
    lcdt_pkg::t_out_item r_s1_item;
    lcdt_pkg::t_rd_src   r_s1_src;
    lcdt_pkg::t_out_item n_item;
    lcdt_pkg::t_rd_src   n_src;

    logic                r_out_valid;
    lcdt_pkg::t_out_item r_out;
    lcdt_pkg::t_out_item s1_done;

    logic        out_free;
    logic        s1_adv;
    logic        accept;
    logic [8:0]  dot_inc;
    logic [7:0]  ly_inc;
    logic [1:0]  req;
    logic [1:0]  cur_mode;
    logic [15:0] vram_off;
    logic [15:0] oam_off;
    logic        vram_hit;
    logic        oam_hit;
    logic [lcdt_pkg::VID_AW-1:0] vram_idx;
    logic [lcdt_pkg::SPR_AW-1:0] oam_idx;
    logic [lcdt_pkg::REG_AW-1:0] reg_idx;
    logic        reg_ok;
    logic        vram_we;
    logic        vram_re;
    logic        oam_we;
    logic        oam_re;

    // handshake
    assign out_free = !r_out_valid || i_ready;
    assign s1_adv   = r_s1_valid && out_free;
    assign o_ready  = !r_s1_valid || out_free;
    assign accept   = i_valid && o_ready;

    // address decode
    assign vram_off = i_item.address - lcdt_pkg::VRAM_BASE;
    assign oam_off  = i_item.address - lcdt_pkg::OAM_BASE;
    assign vram_hit = (i_item.address >= lcdt_pkg::VRAM_BASE)
                   && (i_item.address < lcdt_pkg::VRAM_END)
                   && (32'(vram_off) < lcdt_pkg::VIDEO_BYTES);
    assign oam_hit  = (i_item.address >= lcdt_pkg::OAM_BASE)
                   && (32'(oam_off) < lcdt_pkg::SPRITE_TABLE_BYTES);
    assign vram_idx = lcdt_pkg::VID_AW'(vram_off);
    assign oam_idx  = lcdt_pkg::SPR_AW'(oam_off);
    assign reg_idx  = lcdt_pkg::REG_AW'(i_item.register_index);
    assign reg_ok   = 32'(i_item.register_index) < lcdt_pkg::NUM_REGS;

    assign cur_mode = r_regs[lcdt_pkg::REG_STAT][1:0];
    assign dot_inc  = r_dot + 9'd1;
    assign ly_inc   = r_regs[lcdt_pkg::REG_LY] + 8'd1;

    always_comb begin
        n_regs  = r_regs;
        n_dot   = r_dot;
        n_item  = '0;
        n_src   = lcdt_pkg::RD_SRC_FIX;
        req     = 2'd0;
        vram_we = 1'b0;
        vram_re = 1'b0;
        oam_we  = 1'b0;
        oam_re  = 1'b0;
        case (i_item.command)
            lcdt_pkg::CMD_TICK: begin
                if (r_regs[lcdt_pkg::REG_LCDC][7]) begin
                    if (r_regs[lcdt_pkg::REG_LY] < lcdt_pkg::LINE_VBLANK) begin
                        if (r_dot == 9'd0) begin
                            n_regs[lcdt_pkg::REG_STAT][1:0] = lcdt_pkg::MODE_OAM;
                            if (r_regs[lcdt_pkg::REG_STAT][5]) begin
                                req = req + 2'd1;
                            end
                            n_item.oam_scan_start = 1'b1;
                        end else if (r_dot == lcdt_pkg::DOT_DRAW) begin
                            n_regs[lcdt_pkg::REG_STAT][1:0] = lcdt_pkg::MODE_DRAW;
                            n_item.line_render_start = 1'b1;
                        end else if (r_dot == lcdt_pkg::DOT_HBLANK) begin
                            n_regs[lcdt_pkg::REG_STAT][1:0] = lcdt_pkg::MODE_HBL;
                            if (r_regs[lcdt_pkg::REG_STAT][3]) begin
                                req = req + 2'd1;
                            end
                        end
                    end
                    if (dot_inc == lcdt_pkg::LINE_DOTS) begin
                        n_dot = 9'd0;
                        n_regs[lcdt_pkg::REG_LY] = ly_inc;
                        // lyc match uses the incremented line before the wrap
                        if (r_regs[lcdt_pkg::REG_STAT][6]
                                && ly_inc == r_regs[lcdt_pkg::REG_LYC]) begin
                            req = req + 2'd1;
                        end
                        if (ly_inc == lcdt_pkg::LINE_VBLANK) begin
                            n_regs[lcdt_pkg::REG_STAT][1:0] = lcdt_pkg::MODE_VBL;
                            if (r_regs[lcdt_pkg::REG_STAT][4]) begin
                                req = req + 2'd1;
                            end
                            n_item.vblank_request = 1'b1;
                            n_item.frame_done     = 1'b1;
                        end else if (ly_inc > lcdt_pkg::LINE_LAST) begin
                            n_regs[lcdt_pkg::REG_LY] = 8'd0;
                        end
                    end else begin
                        n_dot = dot_inc;
                    end
                end
            end
            lcdt_pkg::CMD_MEM_READ: begin
                if (vram_hit && cur_mode != lcdt_pkg::MODE_DRAW) begin
                    vram_re = accept;
                    n_src   = lcdt_pkg::RD_SRC_VRAM;
                end else if (oam_hit && cur_mode != lcdt_pkg::MODE_DRAW
                        && cur_mode != lcdt_pkg::MODE_OAM) begin
                    oam_re = accept;
                    n_src  = lcdt_pkg::RD_SRC_OAM;
                end
            end
            lcdt_pkg::CMD_MEM_WRITE: begin
                if (vram_hit && cur_mode != lcdt_pkg::MODE_DRAW) begin
                    vram_we = accept;
                end else if (oam_hit && cur_mode != lcdt_pkg::MODE_DRAW
                        && cur_mode != lcdt_pkg::MODE_OAM) begin
                    oam_we = accept;
                end
            end
            lcdt_pkg::CMD_REG_READ: begin
                if (reg_ok) begin
                    n_item.read_data = r_regs[reg_idx];
                end
            end
            lcdt_pkg::CMD_REG_WRITE: begin
                if (i_item.register_index == lcdt_pkg::REG_LCDC) begin
                    n_regs[lcdt_pkg::REG_LCDC] = i_item.write_data;
                    // display switched off
                    if (r_regs[lcdt_pkg::REG_LCDC][7] && !i_item.write_data[7]) begin
                        n_regs[lcdt_pkg::REG_LY]        = 8'd0;
                        n_dot                           = 9'd0;
                        n_regs[lcdt_pkg::REG_STAT][1:0] = lcdt_pkg::MODE_HBL;
                        n_item.screen_clear             = 1'b1;
                    end
                end else if (i_item.register_index == lcdt_pkg::REG_STAT) begin
                    n_regs[lcdt_pkg::REG_STAT] =
                        (r_regs[lcdt_pkg::REG_STAT] & ~lcdt_pkg::STAT_WMASK)
                        | (i_item.write_data & lcdt_pkg::STAT_WMASK);
                end else if (reg_ok) begin
                    n_regs[reg_idx] = i_item.write_data;
                end
            end
            default: begin
            end
        endcase
        n_item.disp_mode     = n_regs[lcdt_pkg::REG_STAT][1:0];
        n_item.current_line  = n_regs[lcdt_pkg::REG_LY];
        n_item.stat_requests = req;
    end

    // memories; reads only on accept so read data holds while stalled
    always_ff @(posedge i_clk) begin
        if (vram_we) begin
            r_vram[vram_idx] <= i_item.write_data;
        end
        if (vram_re) begin
            r_vram_rdata <= r_vram[vram_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (oam_we) begin
            r_oam[oam_idx] <= i_item.write_data;
        end
        if (oam_re) begin
            r_oam_rdata <= r_oam[oam_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < lcdt_pkg::NUM_REGS; i++) begin
                r_regs[i] <= 8'd0;
            end
            r_dot <= 9'd0;
        end else if (accept) begin
            r_regs <= n_regs;
            r_dot  <= n_dot;
        end
    end

    // read stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_item <= n_item;
            r_s1_src  <= n_src;
        end
    end

    always_comb begin
        s1_done = r_s1_item;
        case (r_s1_src)
            lcdt_pkg::RD_SRC_VRAM: s1_done.read_data = r_vram_rdata;
            lcdt_pkg::RD_SRC_OAM:  s1_done.read_data = r_oam_rdata;
            default:               s1_done.read_data = r_s1_item.read_data;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out <= s1_done;
        end
    end

    assign o_valid = r_out_valid;
    assign o_item  = r_out;

`ifndef NO_ASSERTIONS
    a_dot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dot < lcdt_pkg::LINE_DOTS)
        else $error("dot counter past end of line");

    a_rdata_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !s1_adv |=> $stable(r_vram_rdata) && $stable(r_oam_rdata))
        else $error("memory read data changed under a stalled transaction");

    a_frame_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_item.frame_done |->
            o_item.current_line == lcdt_pkg::LINE_VBLANK
            && o_item.disp_mode == lcdt_pkg::MODE_VBL)
        else $error("frame done outside entry to vblank");

    a_req_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_item.stat_requests != 2'd3)
        else $error("too many status requests in one transaction");
`endif

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import lcdt_pkg::*;

    localparam logic [2:0] CMD_UNUSED_HI    = 3'd7;
    localparam logic [3:0] REG_OUT_OF_RANGE = 4'd15;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int LONG_HOLD      = 300;
    localparam int DRAIN_CYCLES   = 10;
    localparam int PHASE_ITEMS    = 250;

    typedef struct {
        t_in_item  item;
        bit        exact;
        t_out_item want;
    } t_stim_row;

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    logic      o_ready;
    t_in_item  i_item  = '0;
    logic      o_valid;
    logic      i_ready = 1'b0;
    t_out_item o_item;

    // shadow copy of the controller state
    logic [7:0]  sh_vram [VIDEO_BYTES];
    bit          vram_ok [VIDEO_BYTES];
    logic [7:0]  sh_oam  [SPRITE_TABLE_BYTES];
    bit          oam_ok  [SPRITE_TABLE_BYTES];
    logic [7:0]  sh_regs [NUM_REGS];
    logic [8:0]  sh_dot;
    int unsigned vram_list[$];
    int unsigned oam_list[$];

    t_out_item expected_status[$];
    t_stim_row stim_rows[$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_left      = 0;
    int sent_items     = 0;
    int checked_items  = 0;
    int mismatches     = 0;
    int line_ends      = 0;
    int frames_seen    = 0;
    int clears_seen    = 0;
    int idle_cycles;

    lcd_mode_line_timing_controller_top DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_item  (i_item),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_item  (o_item)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic t_rd_src map_bus(input logic [15:0] a, output int unsigned idx);
        idx = 0;
        if (a >= VRAM_BASE && a < VRAM_END) begin
            idx = a - VRAM_BASE;
            if (idx < VIDEO_BYTES) return RD_SRC_VRAM;
            return RD_SRC_FIX;
        end
        if (a >= OAM_BASE) begin
            idx = a - OAM_BASE;
            if (idx < SPRITE_TABLE_BYTES) return RD_SRC_OAM;
        end
        return RD_SRC_FIX;
    endfunction

    function automatic t_out_item predict_lcd_status(input t_in_item it);
        t_out_item   r;
        logic [1:0]  mode;
        logic [7:0]  old_lcdc;
        int unsigned idx;
        t_rd_src     src;
        int          req;
        r = '0;
        req = 0;
        mode = sh_regs[REG_STAT][1:0];
        case (it.command)
            CMD_TICK: begin
                if (sh_regs[REG_LCDC][7]) begin
                    if (sh_regs[REG_LY] < LINE_VBLANK) begin
                        if (sh_dot == 9'd0) begin
                            sh_regs[REG_STAT][1:0] = MODE_OAM;
                            if (sh_regs[REG_STAT][5]) req++;
                            r.oam_scan_start = 1'b1;
                        end else if (sh_dot == DOT_DRAW) begin
                            sh_regs[REG_STAT][1:0] = MODE_DRAW;
                            r.line_render_start = 1'b1;
                        end else if (sh_dot == DOT_HBLANK) begin
                            sh_regs[REG_STAT][1:0] = MODE_HBL;
                            if (sh_regs[REG_STAT][3]) req++;
                        end
                    end
                    sh_dot = sh_dot + 9'd1;
                    if (sh_dot == LINE_DOTS) begin
                        sh_dot = '0;
                        line_ends++;
                        sh_regs[REG_LY] = sh_regs[REG_LY] + 8'd1;
                        // lyc compare sees the incremented value before the wrap
                        if (sh_regs[REG_STAT][6] && sh_regs[REG_LY] == sh_regs[REG_LYC]) req++;
                        if (sh_regs[REG_LY] == LINE_VBLANK) begin
                            sh_regs[REG_STAT][1:0] = MODE_VBL;
                            if (sh_regs[REG_STAT][4]) req++;
                            r.vblank_request = 1'b1;
                            r.frame_done = 1'b1;
                            frames_seen++;
                        end else if (sh_regs[REG_LY] > LINE_LAST) begin
                            sh_regs[REG_LY] = '0;
                        end
                    end
                end
            end
            CMD_MEM_READ: begin
                src = map_bus(it.address, idx);
                if (src == RD_SRC_VRAM && mode != MODE_DRAW) begin
                    r.read_data = sh_vram[idx];
                end else if (src == RD_SRC_OAM && (mode == MODE_HBL || mode == MODE_VBL)) begin
                    r.read_data = sh_oam[idx];
                end
            end
            CMD_MEM_WRITE: begin
                src = map_bus(it.address, idx);
                if (src == RD_SRC_VRAM && mode != MODE_DRAW) begin
                    sh_vram[idx] = it.write_data;
                    if (!vram_ok[idx]) begin
                        vram_ok[idx] = 1'b1;
                        vram_list.push_back(idx);
                    end
                end else if (src == RD_SRC_OAM && (mode == MODE_HBL || mode == MODE_VBL)) begin
                    sh_oam[idx] = it.write_data;
                    if (!oam_ok[idx]) begin
                        oam_ok[idx] = 1'b1;
                        oam_list.push_back(idx);
                    end
                end
            end
            CMD_REG_READ: begin
                if (it.register_index < NUM_REGS) r.read_data = sh_regs[it.register_index];
            end
            CMD_REG_WRITE: begin
                if (it.register_index == REG_LCDC) begin
                    old_lcdc = sh_regs[REG_LCDC];
                    sh_regs[REG_LCDC] = it.write_data;
                    if (old_lcdc[7] && !it.write_data[7]) begin
                        sh_regs[REG_LY] = '0;
                        sh_dot = '0;
                        sh_regs[REG_STAT][1:0] = MODE_HBL;
                        r.screen_clear = 1'b1;
                        clears_seen++;
                    end
                end else if (it.register_index == REG_STAT) begin
                    sh_regs[REG_STAT] = (sh_regs[REG_STAT] & ~STAT_WMASK)
                                      | (it.write_data & STAT_WMASK);
                end else if (it.register_index < NUM_REGS) begin
                    sh_regs[it.register_index] = it.write_data;
                end
            end
            default: begin
            end
        endcase
        r.disp_mode = sh_regs[REG_STAT][1:0];
        r.current_line = sh_regs[REG_LY];
        r.stat_requests = 2'(req);
        return r;
    endfunction

    function automatic string fmt_status(input t_out_item r);
        return $sformatf("rd=%h mode=%0d ly=%0d stat=%0d vbl=%b oam=%b draw=%b frame=%b clr=%b",
                         r.read_data, r.disp_mode, r.current_line, r.stat_requests,
                         r.vblank_request, r.oam_scan_start, r.line_render_start,
                         r.frame_done, r.screen_clear);
    endfunction

    function automatic t_in_item build_item(input logic [2:0] c, input logic [15:0] a,
                                            input logic [3:0] ri, input logic [7:0] d);
        t_in_item it;
        it.command = c;
        it.address = a;
        it.register_index = ri;
        it.write_data = d;
        return it;
    endfunction

    function automatic t_stim_row build_row(input logic [2:0] c, input logic [15:0] a,
                                            input logic [3:0] ri, input logic [7:0] d,
                                            input bit exact, input logic [7:0] rd,
                                            input logic [7:0] ly, input logic clr);
        t_stim_row row;
        row.item = build_item(c, a, ri, d);
        row.exact = exact;
        row.want = '0;
        row.want.read_data = rd;
        row.want.current_line = ly;
        row.want.screen_clear = clr;
        return row;
    endfunction

    // reads only hit entries that were written, or addresses outside both stores
    function automatic logic [15:0] pick_read_addr();
        logic [15:0] a;
        int unsigned idx;
        t_rd_src     src;
        int          k;
        k = $urandom_range(0, 9);
        if (k < 4 && vram_list.size() > 0)
            return VRAM_BASE + 16'(vram_list[$urandom_range(0, vram_list.size() - 1)]);
        if (k < 7 && oam_list.size() > 0)
            return OAM_BASE + 16'(oam_list[$urandom_range(0, oam_list.size() - 1)]);
        if (k == 7)
            return 16'($urandom_range(OAM_BASE + SPRITE_TABLE_BYTES, 16'hFFFF));
        repeat (8) begin
            a = 16'($urandom);
            src = map_bus(a, idx);
            if (src == RD_SRC_FIX) return a;
            if (src == RD_SRC_VRAM && vram_ok[idx]) return a;
            if (src == RD_SRC_OAM && oam_ok[idx]) return a;
        end
        return 16'($urandom_range(0, VRAM_BASE - 1));
    endfunction

    function automatic logic [15:0] pick_write_addr();
        int k;
        k = $urandom_range(0, 9);
        if (k < 5) return VRAM_BASE + 16'($urandom_range(0, VIDEO_BYTES - 1));
        if (k < 8) return OAM_BASE + 16'($urandom_range(0, SPRITE_TABLE_BYTES - 1));
        if (k == 8) return OAM_BASE + 16'($urandom_range(0, 16'h01FF));
        return 16'($urandom);
    endfunction

    function automatic t_in_item rand_access();
        int k;
        k = $urandom_range(0, 9);
        if (k < 4)
            return build_item(CMD_MEM_WRITE, pick_write_addr(), 4'($urandom), 8'($urandom));
        if (k < 7)
            return build_item(CMD_MEM_READ, pick_read_addr(), 4'($urandom), 8'($urandom));
        return build_item(CMD_REG_READ, 16'($urandom), 4'($urandom), 8'($urandom));
    endfunction

    task automatic send_checked(input t_in_item it, input bit exact, input t_out_item want);
        t_out_item model_out;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (o_ready !== 1'b1) @(posedge i_clk);
        model_out = predict_lcd_status(it);
        expected_status.push_back(exact ? want : model_out);
        sent_items++;
    endtask

    task automatic send_item(input t_in_item it);
        send_checked(it, 1'b0, '0);
    endtask

    task automatic display_on_if_off();
        if (!sh_regs[REG_LCDC][7])
            send_item(build_item(CMD_REG_WRITE, 16'($urandom), REG_LCDC, 8'h80 | 8'($urandom)));
    endtask

    // n dot ticks, with bus accesses mixed in between them
    task automatic run_ticks(input int n);
        int ticks;
        ticks = 0;
        while (ticks < n) begin
            if ($urandom_range(0, 99) < 8) begin
                send_item(rand_access());
            end else begin
                send_item(build_item(CMD_TICK, 16'($urandom), 4'($urandom), 8'($urandom)));
                ticks++;
            end
        end
    endtask

    task automatic run_sequence();
        int         sel;
        int         n;
        int         k;
        logic [7:0] v;
        sel = $urandom_range(0, 99);
        if (sel < 40) begin
            if ($urandom_range(0, 9) < 7) display_on_if_off();
            if ($urandom_range(0, 3) == 0) begin
                display_on_if_off();
                run_ticks(int'(LINE_DOTS) - int'(sh_dot));
            end else begin
                run_ticks($urandom_range(1, 60));
            end
        end else if (sel < 55) begin
            // line setup, mostly near the vblank entry and the wrap
            case ($urandom_range(0, 5))
                0: v = LINE_VBLANK - 8'd1;
                1: v = LINE_LAST;
                2: v = 8'hFF;
                3: v = 8'h00;
                4: v = LINE_VBLANK;
                default: v = 8'($urandom);
            endcase
            send_item(build_item(CMD_REG_WRITE, 16'($urandom), REG_LY, v));
            send_item(build_item(CMD_REG_WRITE, 16'($urandom), REG_LYC,
                                 $urandom_range(0, 1) ? v + 8'd1 : 8'($urandom)));
            send_item(build_item(CMD_REG_WRITE, 16'($urandom), REG_STAT, 8'($urandom)));
            if ($urandom_range(0, 1)) begin
                display_on_if_off();
                run_ticks(int'(LINE_DOTS) - int'(sh_dot));
            end
        end else if (sel < 70) begin
            n = $urandom_range(1, 8);
            for (k = 0; k < n; k++) begin
                if ($urandom_range(0, 1))
                    send_item(build_item(CMD_MEM_WRITE, pick_write_addr(), 4'($urandom),
                                         8'($urandom)));
                else
                    send_item(build_item(CMD_MEM_READ, pick_read_addr(), 4'($urandom),
                                         8'($urandom)));
            end
        end else if (sel < 80) begin
            if ($urandom_range(0, 1))
                send_item(build_item(CMD_REG_READ, 16'($urandom),
                                     4'($urandom_range(REG_LCDC, REG_OUT_OF_RANGE)), 8'($urandom)));
            else
                send_item(build_item(CMD_REG_WRITE, 16'($urandom),
                                     4'($urandom_range(REG_STAT, REG_OUT_OF_RANGE)), 8'($urandom)));
        end else if (sel < 88) begin
            v = 8'($urandom);
            if ($urandom_range(0, 3) != 0) v[7] = 1'b1;
            send_item(build_item(CMD_REG_WRITE, 16'($urandom), REG_LCDC, v));
        end else if (sel < 94) begin
            display_on_if_off();
            send_item(build_item(CMD_REG_WRITE, 16'($urandom), REG_LCDC, 8'($urandom) & 8'h7F));
            send_item(build_item(CMD_REG_WRITE, 16'($urandom), REG_LCDC, 8'h80 | 8'($urandom)));
        end else begin
            send_item(build_item(3'($urandom_range(CMD_REG_WRITE + 1, CMD_UNUSED_HI)),
                                 16'($urandom), 4'($urandom), 8'($urandom)));
        end
    endtask

    task automatic check_status(input t_out_item got);
        t_out_item want;
        if (expected_status.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected transaction: %s", fmt_status(got));
        end else begin
            want = expected_status.pop_front();
            checked_items++;
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch on result %0d\n  expected %s\n  actual   %s",
                             checked_items, fmt_status(want), fmt_status(got));
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) check_status(o_item);
        if (hold_left > 0) begin
            i_ready <= 1'b0;
            hold_left--;
        end else begin
            i_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    initial begin
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready)) idle_cycles = 0;
            else idle_cycles++;
        end
        $display("status: fail");
        $finish;
    end

    initial begin
        int i;
        int phase;
        int start_items;
        foreach (sh_regs[j]) sh_regs[j] = '0;
        sh_dot = '0;

        stim_rows.push_back(build_row(CMD_REG_READ, 16'h0000, REG_LCDC, 8'h00, 1, 8'h00, 8'd0, 0));
        stim_rows.push_back(build_row(CMD_TICK, 16'hFFFF, REG_OUT_OF_RANGE, 8'hFF, 1, 8'h00, 8'd0, 0));
        stim_rows.push_back(build_row(CMD_MEM_WRITE, VRAM_BASE, REG_LCDC, 8'hFF, 1, 8'h00, 8'd0, 0));
        stim_rows.push_back(build_row(CMD_MEM_READ, VRAM_BASE, REG_LCDC, 8'h00, 1, 8'hFF, 8'd0, 0));
        stim_rows.push_back(build_row(CMD_MEM_WRITE, VRAM_END - 16'd1, REG_LCDC, 8'h00, 1,
                                      8'h00, 8'd0, 0));
        stim_rows.push_back(build_row(CMD_MEM_READ, VRAM_END - 16'd1, REG_LCDC, 8'hFF, 1,
                                      8'h00, 8'd0, 0));
        stim_rows.push_back(build_row(CMD_MEM_WRITE, OAM_BASE, REG_LCDC, 8'hA5, 1, 8'h00, 8'd0, 0));
        stim_rows.push_back(build_row(CMD_MEM_READ, OAM_BASE, REG_LCDC, 8'h00, 1, 8'hA5, 8'd0, 0));
        stim_rows.push_back(build_row(CMD_MEM_WRITE, 16'(OAM_BASE + SPRITE_TABLE_BYTES - 1),
                                      REG_LCDC, 8'h5A, 1, 8'h00, 8'd0, 0));
        stim_rows.push_back(build_row(CMD_MEM_READ, 16'(OAM_BASE + SPRITE_TABLE_BYTES - 1),
                                      REG_LCDC, 8'h00, 1, 8'h5A, 8'd0, 0));
        // just past the end of the sprite table and of video memory
        stim_rows.push_back(build_row(CMD_MEM_WRITE, 16'(OAM_BASE + SPRITE_TABLE_BYTES),
                                      REG_LCDC, 8'h77, 1, 8'h00, 8'd0, 0));
        stim_rows.push_back(build_row(CMD_MEM_READ, 16'(OAM_BASE + SPRITE_TABLE_BYTES),
                                      REG_LCDC, 8'h00, 1, 8'h00, 8'd0, 0));
        stim_rows.push_back(build_row(CMD_MEM_WRITE, VRAM_END, REG_LCDC, 8'h33, 1, 8'h00, 8'd0, 0));
        stim_rows.push_back(build_row(CMD_MEM_READ, VRAM_END, REG_LCDC, 8'h00, 1, 8'h00, 8'd0, 0));
        stim_rows.push_back(build_row(CMD_MEM_READ, 16'hFFFF, REG_LCDC, 8'h00, 1, 8'h00, 8'd0, 0));
        stim_rows.push_back(build_row(CMD_MEM_READ, 16'h0000, REG_LCDC, 8'h00, 1, 8'h00, 8'd0, 0));
        // stat write keeps the mode bits
        stim_rows.push_back(build_row(CMD_REG_WRITE, 16'h0000, REG_STAT, 8'hFF, 1, 8'h00, 8'd0, 0));
        stim_rows.push_back(build_row(CMD_REG_READ, 16'h0000, REG_STAT, 8'h00, 1, STAT_WMASK,
                                      8'd0, 0));
        stim_rows.push_back(build_row(CMD_REG_WRITE, 16'h0000, REG_OUT_OF_RANGE, 8'hFF, 1,
                                      8'h00, 8'd0, 0));
        stim_rows.push_back(build_row(CMD_REG_READ, 16'h0000, REG_OUT_OF_RANGE, 8'h00, 1,
                                      8'h00, 8'd0, 0));
        stim_rows.push_back(build_row(CMD_UNUSED_HI, 16'hFFFF, REG_OUT_OF_RANGE, 8'hFF, 1,
                                      8'h00, 8'd0, 0));
        stim_rows.push_back(build_row(CMD_REG_WRITE, 16'h0000, REG_LY, LINE_VBLANK - 8'd1, 1,
                                      8'h00, LINE_VBLANK - 8'd1, 0));
        stim_rows.push_back(build_row(CMD_REG_WRITE, 16'h0000, REG_LCDC, 8'hFF, 0, 8'h00, 8'd0, 0));
        stim_rows.push_back(build_row(CMD_TICK, 16'h0000, REG_LCDC, 8'h00, 0, 8'h00, 8'd0, 0));
        stim_rows.push_back(build_row(CMD_MEM_READ, OAM_BASE, REG_LCDC, 8'h00, 0, 8'h00, 8'd0, 0));
        stim_rows.push_back(build_row(CMD_MEM_READ, VRAM_BASE, REG_LCDC, 8'h00, 0, 8'h00, 8'd0, 0));
        // display off clears line, dot counter and mode
        stim_rows.push_back(build_row(CMD_REG_WRITE, 16'h0000, REG_LCDC, 8'h00, 1, 8'h00, 8'd0, 1));

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (i = 0; i < stim_rows.size(); i++)
            send_checked(stim_rows[i].item, stim_rows[i].exact, stim_rows[i].want);

        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                    // receiver holds off so the block backs up into its input
                    hold_left = LONG_HOLD;
                end
                1: begin
                    send_idle_pct = 67;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    recv_stall_pct = 67;
                end
                default: begin
                    send_idle_pct = 14;
                    recv_stall_pct = 14;
                end
            endcase
            start_items = sent_items;
            while (sent_items - start_items < PHASE_ITEMS)
                run_sequence();
        end
        i_valid <= 1'b0;

        while (expected_status.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("ran %0d transactions in four handshake phases, %0d checked, %0d mismatches",
                 sent_items, checked_items, mismatches);
        $display("timing covered %0d line ends, %0d vblank entries, %0d display-off clears",
                 line_ends, frames_seen, clears_seen);
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ===== lcd_mode_line_timing_controller_top.f =====
hw/rtl/lcdt_pkg.sv
hw/rtl/lcd_mode_line_timing_controller_top.sv
tb/sv/tb_top.sv
